@@ sv/fh_pkg.sv @@
// fh_pkg: shared types, constants and the product schedule table
// for the focal-from-homography block; no dependencies
`default_nettype none
package fh_pkg;

  localparam int HW     = 48;          // width of one homography entry
  localparam int HALF   = HW / 2;      // partial product operand width
  localparam int SW     = 98;          // width of an exact sum of products
  localparam int NPROD  = 14;          // products formed per transaction
  localparam int FSTEPS = NPROD * 4;   // partial products per transaction
  localparam int QW     = 62;          // quotient bits below the saturation limit
  localparam int RTW    = 32;          // root width
  localparam int FW     = 24;          // focal code width

  typedef struct packed {
    logic [HW-1:0] h00;
    logic [HW-1:0] h01;
    logic [HW-1:0] h02;
    logic [HW-1:0] h10;
    logic [HW-1:0] h11;
    logic [HW-1:0] h12;
    logic [HW-1:0] h20;
    logic [HW-1:0] h21;
  } hin_t;

  typedef struct packed {
    logic [FW-1:0] focal_src;
    logic [FW-1:0] focal_dst;
    logic          src_ok;
    logic          dst_ok;
  } fout_t;

  typedef enum logic [2:0] {H00, H01, H02, H10, H11, H12, H20, H21} hsel_t;

  // numerators and denominators: destination first, then source
  typedef enum logic [2:0] {D_N1, D_D1, D_N2, D_D2, S_N1, S_D1, S_N2, S_D2} vsel_t;

  typedef struct packed {
    hsel_t a;
    hsel_t b;
    vsel_t t0;
    logic  n0;
    vsel_t t1;
    logic  e1;
    logic  n1;
  } prod_op_t;

  typedef struct packed {
    logic                 dz;
    logic [7:0][SW-1:0]   val;
  } qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // which entries to multiply and where the product goes, with sign
  function automatic prod_op_t prod_op(input logic [3:0] p);
    prod_op_t op;
    case (p)
      4'd0:    op = '{H00, H00, D_N2, 1'b0, S_D2, 1'b1, 1'b0};
      4'd1:    op = '{H01, H01, D_N2, 1'b1, S_D2, 1'b1, 1'b0};
      4'd2:    op = '{H10, H10, D_N2, 1'b0, S_D2, 1'b1, 1'b1};
      4'd3:    op = '{H11, H11, D_N2, 1'b1, S_D2, 1'b1, 1'b1};
      4'd4:    op = '{H20, H21, D_D1, 1'b0, D_D1, 1'b0, 1'b0};
      4'd5:    op = '{H21, H21, D_D2, 1'b0, D_D2, 1'b0, 1'b0};
      4'd6:    op = '{H20, H20, D_D2, 1'b1, D_D2, 1'b0, 1'b0};
      4'd7:    op = '{H00, H01, D_N1, 1'b1, D_N1, 1'b0, 1'b0};
      4'd8:    op = '{H10, H11, D_N1, 1'b1, D_N1, 1'b0, 1'b0};
      4'd9:    op = '{H00, H10, S_D1, 1'b0, S_D1, 1'b0, 1'b0};
      4'd10:   op = '{H01, H11, S_D1, 1'b0, S_D1, 1'b0, 1'b0};
      4'd11:   op = '{H02, H12, S_N1, 1'b1, S_N1, 1'b0, 1'b0};
      4'd12:   op = '{H12, H12, S_N2, 1'b0, S_N2, 1'b0, 1'b0};
      4'd13:   op = '{H02, H02, S_N2, 1'b1, S_N2, 1'b0, 1'b0};
      default: op = '{H00, H00, D_N1, 1'b0, D_N1, 1'b0, 1'b0};
    endcase
    return op;
  endfunction

  function automatic logic [HW-1:0] mag48(input logic [HW-1:0] x);
    return x[HW-1] ? (~x + {{(HW-1){1'b0}}, 1'b1}) : x;
  endfunction

  function automatic logic [SW-1:0] absw(input logic [SW-1:0] x);
    return x[SW-1] ? (~x + {{(SW-1){1'b0}}, 1'b1}) : x;
  endfunction

endpackage
`default_nettype wire

@@ sv/fh_front.sv @@
// fh_front: takes a homography, forms the eight exact sums of products
// with one 24x24 multiplier, flags zero denominators; uses fh_pkg
`default_nettype none
module fh_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  fh_pkg::hin_t  homog,
  output logic          busy,
  output logic          push,
  output fh_pkg::qent_t push_data,
  input  fh_pkg::qstat_t qs
);
  import fh_pkg::*;

  localparam int CW = $clog2(FSTEPS + 1);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_RUN   = 4'b0010,
    F_DRAIN = 4'b0100,
    F_PUSH  = 4'b1000
  } fst_t;

  fst_t            state;
  logic [CW-1:0]   cnt;
  logic            v1;
  logic [HW-1:0]   hv [8];
  logic [HW-1:0]   mag_a [8];
  logic [HW-1:0]   mag_b [8];
  logic            sgn_a [8];
  logic            sgn_b [8];
  logic [SW-1:0]   acc [8];
  logic [HW-1:0]   part;
  logic [1:0]      sh;
  vsel_t           t0, t1;
  logic            n0, e1, n1;
  prod_op_t        op;
  logic [HALF-1:0] ah, bh;
  logic            pneg;
  logic [SW-1:0]   xs;

  assign hv[0] = homog.h00;
  assign hv[1] = homog.h01;
  assign hv[2] = homog.h02;
  assign hv[3] = homog.h10;
  assign hv[4] = homog.h11;
  assign hv[5] = homog.h12;
  assign hv[6] = homog.h20;
  assign hv[7] = homog.h21;

  assign busy = (state != F_IDLE);
  assign push = (state == F_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
      v1    <= 1'b0;
    end else begin
      case (state)
        F_IDLE: if (start) begin
          state <= F_RUN;
          cnt   <= '0;
        end
        F_RUN: begin
          if (cnt == CW'(FSTEPS - 1)) state <= F_DRAIN;
          cnt <= cnt + 1'b1;
        end
        F_DRAIN: state <= F_PUSH;
        F_PUSH: if (!qs.full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
      v1 <= (state == F_RUN);
    end
  end

  // partial product select
  always_comb begin
    op   = prod_op(cnt[5:2]);
    ah   = cnt[1] ? mag_a[op.a][HW-1:HALF] : mag_a[op.a][HALF-1:0];
    bh   = cnt[0] ? mag_b[op.b][HW-1:HALF] : mag_b[op.b][HALF-1:0];
    pneg = sgn_a[op.a] ^ sgn_b[op.b];
  end

  always_comb begin
    case (sh)
      2'd0:    xs = SW'(part);
      2'd1:    xs = SW'(part) << HALF;
      2'd2:    xs = SW'(part) << HW;
      default: xs = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      for (int i = 0; i < 8; i++) begin
        mag_a[i] <= mag48(hv[i]);
        mag_b[i] <= mag48(hv[i]);
        sgn_a[i] <= hv[i][HW-1];
        sgn_b[i] <= hv[i][HW-1];
        acc[i]   <= '0;
      end
    end else if (v1) begin
      for (int i = 0; i < 8; i++) begin
        if (t0 == vsel_t'(i)) begin
          acc[i] <= n0 ? acc[i] - xs : acc[i] + xs;
        end else if (e1 && t1 == vsel_t'(i)) begin
          acc[i] <= n1 ? acc[i] - xs : acc[i] + xs;
        end
      end
    end
    part <= ah * bh;
    sh   <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
    t0   <= op.t0;
    n0   <= op.n0 ^ pneg;
    t1   <= op.t1;
    e1   <= op.e1;
    n1   <= op.n1 ^ pneg;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) push_data.val[i] = acc[i];
    push_data.dz = (acc[D_D1] == '0) || (acc[D_D2] == '0) ||
                   (acc[S_D1] == '0) || (acc[S_D2] == '0);
  end

endmodule
`default_nettype wire

@@ sv/fh_queue.sv @@
// fh_queue: two-entry queue of classified sums between front and back
// uses fh_pkg
`default_nettype none
module fh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fh_pkg::qent_t  push_data,
  input  logic           pop,
  output fh_pkg::qent_t  head,
  output fh_pkg::qstat_t qs
);
  import fh_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  qent_t         mem [DEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   cnt;
  logic          do_push, do_pop;

  assign qs.full  = (cnt == (PW+1)'(DEPTH));
  assign qs.empty = (cnt == '0);
  assign do_push  = push && !qs.full;
  assign do_pop   = pop && !qs.empty;
  assign head     = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      cnt <= cnt + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_data;
  end

endmodule
`default_nettype wire

@@ sv/fh_back.sv @@
// fh_back: four restoring divider lanes, candidate selection and two
// bit-pair square root lanes; uses fh_pkg
`default_nettype none
module fh_back #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  fh_pkg::qent_t  head,
  input  fh_pkg::qstat_t qs,
  output logic           pop,
  output logic           done,
  output fh_pkg::fout_t  focal
);
  import fh_pkg::*;

  localparam int SHF = 2 * OUT_FRAC_BITS;
  localparam int NW  = SW + SHF;

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_PREP = 7'b0000010,
    B_DIV  = 7'b0000100,
    B_FIN  = 7'b0001000,
    B_SEL  = 7'b0010000,
    B_SQRT = 7'b0100000,
    B_OUT  = 7'b1000000
  } bst_t;

  bst_t          state;
  logic [5:0]    cnt;
  logic [SW-1:0] nab [4];
  logic [SW-1:0] dab [4];
  logic          nsg [4];
  logic          dz;
  logic          sat [4];
  logic [SW-1:0] rem [4];
  logic [QW-1:0] nb [4];
  logic [QW-1:0] quo [4];
  logic [63:0]   ratio [4];
  logic          dgt [2];
  logic          ok [2];
  logic [63:0]   sv [2];
  logic [33:0]   srem [2];
  logic [RTW-1:0] root [2];

  logic [NW-1:0] nsh [4];
  logic [NW-1:0] hi [4];
  logic          sat_n [4];
  logic [SW:0]   r2 [4];
  logic [SW:0]   rsub [4];
  logic          ge [4];
  logic [QW:0]   mq [4];
  logic [63:0]   rat_n [4];
  logic [62:0]   pick_n [2];
  logic          ok_n [2];
  logic [35:0]   t [2];
  logic [35:0]   trial [2];
  logic [35:0]   tsub [2];
  logic          sge [2];
  logic          big [2];
  logic          bad;

  assign pop = (state == B_IDLE) && !qs.empty;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nsh[i]   = NW'(nab[i]) << SHF;
      hi[i]    = nsh[i] >> QW;
      sat_n[i] = hi[i] >= NW'(dab[i]);
      r2[i]    = {rem[i], nb[i][QW-1]};
      rsub[i]  = r2[i] - {1'b0, dab[i]};
      ge[i]    = r2[i] >= {1'b0, dab[i]};
      mq[i]    = sat[i] ? {1'b1, {QW{1'b0}}} : {1'b0, quo[i]};
      rat_n[i] = nsg[i] ? (64'd0 - {1'b0, mq[i]}) : {1'b0, mq[i]};
    end
  end

  // keep the positive candidate, or pick by denominator size when both positive; none if neither
  always_comb begin
    logic signed [63:0] ra, rb, qh, ql;
    for (int e = 0; e < 2; e++) begin
      ra = $signed(ratio[2*e]);
      rb = $signed(ratio[2*e+1]);
      qh = (ra >= rb) ? ra : rb;
      ql = (ra >= rb) ? rb : ra;
      if (qh > 0 && ql > 0) begin
        pick_n[e] = dgt[e] ? qh[62:0] : ql[62:0];
        ok_n[e]   = 1'b1;
      end else if (qh > 0) begin
        pick_n[e] = qh[62:0];
        ok_n[e]   = 1'b1;
      end else begin
        pick_n[e] = '0;
        ok_n[e]   = 1'b0;
      end
    end
  end

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      t[e]     = {srem[e], sv[e][63:62]};
      trial[e] = {2'b00, root[e], 2'b01};
      tsub[e]  = t[e] - trial[e];
      sge[e]   = t[e] >= trial[e];
      big[e]   = root[e][RTW-1:FW] != '0;
    end
    bad = dz || (ok[0] && big[0]) || (ok[1] && big[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        B_IDLE: if (!qs.empty) state <= B_PREP;
        B_PREP: begin
          state <= B_DIV;
          cnt   <= '0;
        end
        B_DIV: begin
          if (cnt == 6'(QW - 1)) state <= B_FIN;
          cnt <= cnt + 1'b1;
        end
        B_FIN: state <= B_SEL;
        B_SEL: begin
          state <= B_SQRT;
          cnt   <= '0;
        end
        B_SQRT: begin
          if (cnt == 6'(RTW - 1)) state <= B_OUT;
          cnt <= cnt + 1'b1;
        end
        B_OUT: begin
          state <= B_IDLE;
          done  <= 1'b1;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        dz <= head.dz;
        for (int i = 0; i < 4; i++) begin
          nab[i] <= absw(head.val[2*i]);
          dab[i] <= absw(head.val[2*i+1]);
          nsg[i] <= head.val[2*i][SW-1] ^ head.val[2*i+1][SW-1];
        end
      end
      B_PREP: begin
        for (int i = 0; i < 4; i++) begin
          sat[i] <= sat_n[i];
          rem[i] <= sat_n[i] ? '0 : hi[i][SW-1:0];
          nb[i]  <= nsh[i][QW-1:0];
          quo[i] <= '0;
        end
        for (int e = 0; e < 2; e++) dgt[e] <= dab[2*e] > dab[2*e+1];
      end
      B_DIV: begin
        for (int i = 0; i < 4; i++) begin
          rem[i] <= ge[i] ? rsub[i][SW-1:0] : r2[i][SW-1:0];
          quo[i] <= {quo[i][QW-2:0], ge[i]};
          nb[i]  <= {nb[i][QW-2:0], 1'b0};
        end
      end
      B_FIN: begin
        for (int i = 0; i < 4; i++) ratio[i] <= rat_n[i];
      end
      B_SEL: begin
        for (int e = 0; e < 2; e++) begin
          ok[e]   <= ok_n[e];
          sv[e]   <= {1'b0, pick_n[e]};
          srem[e] <= '0;
          root[e] <= '0;
        end
      end
      B_SQRT: begin
        for (int e = 0; e < 2; e++) begin
          srem[e] <= sge[e] ? tsub[e][33:0] : t[e][33:0];
          root[e] <= {root[e][RTW-2:0], sge[e]};
          sv[e]   <= {sv[e][61:0], 2'b00};
        end
      end
      B_OUT: begin
        focal.dst_ok    <= ok[0] && !bad;
        focal.src_ok    <= ok[1] && !bad;
        focal.focal_dst <= (ok[0] && !bad) ? root[0][FW-1:0] : '0;
        focal.focal_src <= (ok[1] && !bad) ? root[1][FW-1:0] : '0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/focal_from_homography.sv @@
// focal_from_homography: top level; front product unit, queue, back
// divide/select/root unit; uses fh_pkg, fh_front, fh_queue, fh_back
//
// channel  | ports                 | handshake
// ---------+-----------------------+------------------------------------------
// input    | start, busy, homog    | transaction taken when start && !busy
// result   | done, focal           | transaction shown for one cycle on done
//
// the front forms 56 partial products per transaction on one 24x24
// multiplier (fourteen 48x48 products), then drains, pushes and idles;
// the back pops, prepares, forms 62 quotient bits in four divider lanes,
// fixes up, selects, takes 32 root steps and outputs, and pops the next
// transaction only after the last one is output
// busy stays high while the front works or waits on the full two-entry queue;
// synchronous reset empties the queue and idles both parts; done pulses once
`default_nettype none
module focal_from_homography #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  fh_pkg::hin_t  homog,
  output logic          busy,
  output logic          done,
  output fh_pkg::fout_t focal
);
  import fh_pkg::*;

  // front to queue
  logic   push;
  qent_t  push_data;
  // queue to back
  qent_t  head;
  qstat_t qs;
  logic   pop;

  fh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .homog     (homog),
    .busy      (busy),
    .push      (push),
    .push_data (push_data),
    .qs        (qs)
  );

  fh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qs        (qs)
  );

  fh_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qs    (qs),
    .pop   (pop),
    .done  (done),
    .focal (focal)
  );

endmodule
`default_nettype wire

@@ sv/fh_check.sv @@
// fh_check: port-level checks for focal_from_homography and its bind
// uses fh_pkg
`default_nettype none
module fh_check (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input fh_pkg::fout_t focal
);

  // a taken transaction leaves the front busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low right after a transaction was taken");

  // every done strobe is followed by done low
  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done high in two cycles in a row");

  a_src_zero: assert property (@(posedge clk) disable iff (rst)
    done && !focal.src_ok |-> focal.focal_src == '0)
    else $error("invalid source focal not zero");

  a_dst_zero: assert property (@(posedge clk) disable iff (rst)
    done && !focal.dst_ok |-> focal.focal_dst == '0)
    else $error("invalid destination focal not zero");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("not idle after reset");

endmodule

bind focal_from_homography fh_check u_check (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .focal (focal)
);
`default_nettype wire

@@ bench/tb_focal_from_homography.sv @@
// tb_focal_from_homography: self-checking bench for the focal-from-homography block
// with a bit-exact focal predictor and an expected-result queue
// depends on fh_pkg and focal_from_homography
`timescale 1ns / 1ps
`default_nettype none
module tb_focal_from_homography;
  import fh_pkg::*;

  localparam int  OUT_FRAC  = 8;
  localparam int  TIMEOUT   = 600000;
  localparam int  N_RANDOM  = 530;
  localparam int  DRAIN     = 400;

  typedef logic signed [127:0] wide_t;

  // focal predictor and queue of predicted results
  class focal_scoreboard;
    fout_t pending_q[$];
    int    errors;

    function new();
      errors = 0;
    endfunction

    // exact signed product of two 48-bit entries
    function wide_t mul48(logic [HW-1:0] a, logic [HW-1:0] b);
      wide_t sa, sb;
      sa = {{80{a[HW-1]}}, a};
      sb = {{80{b[HW-1]}}, b};
      return sa * sb;
    endfunction

    function wide_t mag(wide_t x);
      return x[127] ? -x : x;
    endfunction

    // scaled quotient, truncated toward zero, magnitude capped at 2^62
    function longint quotient(wide_t n, wide_t d);
      logic [127:0] q;
      logic [127:0] lim;
      longint m;
      lim = 128'd1 << 62;
      q = (unsigned'(mag(n)) << (2 * OUT_FRAC)) / unsigned'(mag(d));
      m = (q > lim) ? longint'(lim) : longint'(q);
      return (n[127] ^ d[127]) ? -m : m;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void estimate(input wide_t n1, d1, n2, d2, output bit ok,
                           output logic [FW-1:0] f, inout bit bad);
      longint q1, q2, t, pick;
      longint unsigned r;
      ok = 0;
      f  = '0;
      if (d1 == 0 || d2 == 0) begin
        bad = 1;
        return;
      end
      q1 = quotient(n1, d1);
      q2 = quotient(n2, d2);
      if (q1 < q2) begin
        t = q1; q1 = q2; q2 = t;
      end
      if (q1 > 0 && q2 > 0) pick = (mag(d1) > mag(d2)) ? q1 : q2;
      else if (q1 > 0) pick = q1;
      else return;
      r = root(unsigned'(pick));
      if (r > 64'hFFFFFF) bad = 1;
      f  = r[FW-1:0];
      ok = 1;
    endfunction

    // predict the result of one accepted transaction
    function void note(hin_t h);
      wide_t s00, s01, s10, s11;
      bit ok_s, ok_d, bad;
      logic [FW-1:0] f_s, f_d;
      fout_t r;
      s00 = mul48(h.h00, h.h00);
      s01 = mul48(h.h01, h.h01);
      s10 = mul48(h.h10, h.h10);
      s11 = mul48(h.h11, h.h11);
      bad = 0;
      estimate(-(mul48(h.h00, h.h01) + mul48(h.h10, h.h11)), mul48(h.h20, h.h21),
               s00 + s10 - s01 - s11,
               mul48(h.h21, h.h21) - mul48(h.h20, h.h20), ok_d, f_d, bad);
      estimate(-mul48(h.h02, h.h12), mul48(h.h00, h.h10) + mul48(h.h01, h.h11),
               mul48(h.h12, h.h12) - mul48(h.h02, h.h02),
               s00 + s01 - s10 - s11, ok_s, f_s, bad);
      if (bad) begin
        ok_s = 0;
        ok_d = 0;
      end
      r.focal_src = ok_s ? f_s : '0;
      r.focal_dst = ok_d ? f_d : '0;
      r.src_ok    = ok_s;
      r.dst_ok    = ok_d;
      pending_q = {pending_q, r};
    endfunction

    function void check(fout_t got);
      fout_t e;
      if (pending_q.size() == 0) begin
        $error("result with no transaction outstanding: %h", got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.focal_src !== e.focal_src) begin
        $error("focal_src expected %h actual %h", e.focal_src, got.focal_src);
        errors++;
      end
      if (got.focal_dst !== e.focal_dst) begin
        $error("focal_dst expected %h actual %h", e.focal_dst, got.focal_dst);
        errors++;
      end
      if (got.src_ok !== e.src_ok) begin
        $error("src_ok expected %b actual %b", e.src_ok, got.src_ok);
        errors++;
      end
      if (got.dst_ok !== e.dst_ok) begin
        $error("dst_ok expected %b actual %b", e.dst_ok, got.dst_ok);
        errors++;
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  hin_t  homog = '0;
  logic  busy, done;
  fout_t focal;
  int    cycles = 0;

  focal_scoreboard sb = new();

  focal_from_homography #(.OUT_FRAC_BITS(OUT_FRAC)) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .homog(homog),
    .busy (busy),
    .done (done),
    .focal(focal)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT) begin
      $display("FAIL focal_from_homography");
      $finish;
    end
  end

  // results cannot be stalled: sample every strobe
  always @(posedge clk) begin
    if (!rst && done) sb.check(focal);
  end

  // present one transaction after a random gap, possibly none; start stays high
  // across back-to-back transactions with no gap and drops before any gap
  task automatic send(hin_t h);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    homog <= h;
    do @(posedge clk); while (busy);
    sb.note(h);
  endtask

  function automatic hin_t mk(longint a, b, c, d, e, f, g, k);
    hin_t h;
    h.h00 = a[HW-1:0]; h.h01 = b[HW-1:0]; h.h02 = c[HW-1:0];
    h.h10 = d[HW-1:0]; h.h11 = e[HW-1:0]; h.h12 = f[HW-1:0];
    h.h20 = g[HW-1:0]; h.h21 = k[HW-1:0];
    return h;
  endfunction

  // entry of random magnitude so that ratios spread over the whole range
  function automatic logic [HW-1:0] rand_entry();
    logic [HW-1:0] v;
    int w;
    v = HW'({$urandom, $urandom});
    if ($urandom_range(0, 14) == 0) return v;        // any 48-bit pattern
    if ($urandom_range(0, 19) == 0) return '0;       // zero entry
    w = $urandom_range(1, 47);
    v = v >> (HW - w);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  localparam longint ONE  = 64'sd1 << 32;
  localparam longint MAXV = (64'sd1 << 47) - 1;
  localparam longint MINV = -(64'sd1 << 47);

  initial begin
    hin_t h;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: zeros, extremes, identity, plausible homographies,
    // tiny candidates and an oversized root
    send(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    send(mk(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV));
    send(mk(MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV));
    send(mk(-1, -1, -1, -1, -1, -1, -1, -1));
    send(mk(ONE, 0, 0, 0, ONE, 0, 0, 0));
    send(mk(ONE, ONE / 50, 300 * ONE, -ONE / 40, ONE, 20 * ONE, 4000, -3000));
    send(mk(ONE + 7777, -ONE / 9, -150 * ONE, ONE / 11, ONE - 999, 75 * ONE,
            1 << 21, 1 << 20));
    send(mk(2 * ONE, ONE / 3, 500 * ONE, ONE / 5, 3 * ONE, -200 * ONE, -12345, 54321));
    send(mk(1, 1, MAXV, 1, 2, MAXV, 1, 2));
    send(mk(MAXV, MAXV, 1, MINV, MAXV, 1, MAXV, MAXV));
    send(mk(MAXV, 1, 0, 1, 1, 0, 1, 1));
    send(mk(3, 5, MINV, 7, 11, MAXV, MINV, 1));
    send(mk(ONE, 1, 100 * ONE, 1, ONE, 100 * ONE, 1, 1));
    send(mk(MAXV, 0, 0, 0, 1, 0, 1, 2));
    send(mk(1, 2, MAXV, 3, 1, MINV, 1, -1));
    send(mk(ONE, -ONE, 7 * ONE, ONE, ONE, -7 * ONE, 5, 9));
    send(mk(-ONE, ONE / 2, ONE, ONE / 2, -ONE, ONE, -ONE, ONE / 3));

    for (int i = 0; i < N_RANDOM; i++) begin
      h.h00 = rand_entry(); h.h01 = rand_entry(); h.h02 = rand_entry();
      h.h10 = rand_entry(); h.h11 = rand_entry(); h.h12 = rand_entry();
      h.h20 = rand_entry(); h.h21 = rand_entry();
      send(h);
    end
    start <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS focal_from_homography");
    end else begin
      $display("FAIL focal_from_homography");
    end
    $finish;
  end

endmodule
`default_nettype wire
